### src/itw_pkg.sv
// ----------------------------------------------------------------------------
// itw_pkg
// Shared types and constants for the I2C timing word calculator.
// ----------------------------------------------------------------------------
package itw_pkg;

   localparam int CLK_W      = 30;
   localparam int FREQ_W     = 24;
   localparam int WORD_W     = 32;
   localparam int DIVIDEND_W = 30;
   localparam int DIVISOR_W  = 20;
   localparam int MHZ_W      = 11;
   localparam int STEP_W     = 14;
   localparam int QUO_W      = 13;
   localparam int CNT_W      = $clog2(DIVIDEND_W);

   localparam logic [CLK_W-1:0]     CLK_RESET  = 30'd64000000;
   localparam logic [FREQ_W-1:0]    STD_LIMIT  = 24'd100000;
   localparam logic [FREQ_W-1:0]    FAST_LIMIT = 24'd400000;
   localparam logic [DIVISOR_W-1:0] HZ_PER_MHZ = 20'd1000000;
   localparam logic [QUO_W-1:0]     FIT_LIMIT  = 13'd256;
   localparam logic [3:0]           PRE_LAST   = 4'd15;
   localparam logic [7:0]           CNT_MAX    = 8'd255;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MHZ  = 6'b000010,
      ST_STEP = 6'b000100,
      ST_LOW  = 6'b001000,
      ST_HIGH = 6'b010000,
      ST_OUT  = 6'b100000
   } state_type;

   // Prescaler step numerator: (p + 1) * 1000 ns.
   function automatic logic [STEP_W-1:0] step_num(input logic [3:0] p);
      return STEP_W'(({10'd0, p} + 14'd1) * 14'd1000);
   endfunction

endpackage

### src/itw_chan_if.sv
// ----------------------------------------------------------------------------
// itw_req_if / itw_rsp_if
// Valid/ready channels for the request and the response item.
// ----------------------------------------------------------------------------
interface itw_req_if import itw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FREQ_W-1:0] bus_freq_hz;

   modport source (output valid, output bus_freq_hz, input ready);
   modport sink   (input valid, input bus_freq_hz, output ready);
endinterface

interface itw_rsp_if import itw_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] timing_word;

   modport source (output valid, output timing_word, input ready);
   modport sink   (input valid, input timing_word, output ready);
endinterface

### src/itw_div.sv
// ----------------------------------------------------------------------------
// itw_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module itw_div import itw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   assign shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign ge      = shifted >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W - 1);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

### src/i2c_timing_word_calculator.sv
// ----------------------------------------------------------------------------
// i2c_timing_word_calculator
// Prescaler search for the I2C SCL timing word, on a shared serial divider.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake      Payload
//  req_chan  in   valid/ready    bus_freq_hz  [23:0]
//  rsp_chan  out  valid/ready    timing_word  [31:0]
//  csr       in   csr_we         csr_wdata    [29:0] peripheral clock, Hz
//
//  One item in flight. The divisions run one after another on the divider:
//  one for the clock in MHz, then per prescaler trial one for the step and,
//  for a nonzero step, two for the counts.
//  Reset returns to idle with the clock register at 64 MHz.
//  The result is held in the output register until rsp_chan.ready.
// ----------------------------------------------------------------------------
module i2c_timing_word_calculator import itw_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   itw_req_if.sink          req_chan,
   itw_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [CLK_W-1:0] csr_wdata
);

   state_type          state_ff, state_in;
   logic [CLK_W-1:0]   clk_hz_ff;
   logic [12:0]        low_ns_ff, low_ns_in;
   logic [12:0]        high_ns_ff, high_ns_in;
   logic [3:0]         data_dly_ff, data_dly_in;
   logic [3:0]         clk_dly_ff, clk_dly_in;
   logic [MHZ_W-1:0]   mhz_ff, mhz_in;
   logic [3:0]         pre_ff, pre_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [QUO_W-1:0]   qlo_ff, qlo_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic [QUO_W-1:0]   qhi;
   logic               accept;

   itw_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept = req_chan.valid && req_chan.ready;
   assign qhi    = div_rsp.quotient[QUO_W-1:0];

   always_comb begin
      state_in    = state_ff;
      low_ns_in   = low_ns_ff;
      high_ns_in  = high_ns_ff;
      data_dly_in = data_dly_ff;
      clk_dly_in  = clk_dly_ff;
      mhz_in      = mhz_ff;
      pre_in      = pre_ff;
      step_in     = step_ff;
      qlo_in      = qlo_ff;
      word_in     = word_ff;
      div_req     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.bus_freq_hz <= STD_LIMIT) begin
                  low_ns_in = 13'd4700; high_ns_in = 13'd4000;
                  data_dly_in = 4'd2; clk_dly_in = 4'd4;
               end else if (req_chan.bus_freq_hz <= FAST_LIMIT) begin
                  low_ns_in = 13'd1300; high_ns_in = 13'd600;
                  data_dly_in = 4'd1; clk_dly_in = 4'd3;
               end else begin
                  low_ns_in = 13'd500; high_ns_in = 13'd260;
                  data_dly_in = 4'd0; clk_dly_in = 4'd1;
               end
               div_req.start    = 1'b1;
               div_req.dividend = clk_hz_ff;
               div_req.divisor  = HZ_PER_MHZ;
               state_in         = ST_MHZ;
            end
         end
         ST_MHZ: begin
            if (div_rsp.done) begin
               mhz_in = div_rsp.quotient[MHZ_W-1:0];
               pre_in = '0;
               if (div_rsp.quotient == '0) begin
                  word_in  = {PRE_LAST, 4'd0, clk_dly_ff, data_dly_ff, CNT_MAX, CNT_MAX};
                  state_in = ST_OUT;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIVIDEND_W'(step_num(4'd0));
                  div_req.divisor  = DIVISOR_W'(div_rsp.quotient[MHZ_W-1:0]);
                  state_in         = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            if (div_rsp.done) begin
               step_in = div_rsp.quotient[STEP_W-1:0];
               if (div_rsp.quotient == '0) begin
                  if (pre_ff == PRE_LAST) begin
                     word_in  = {PRE_LAST, 4'd0, clk_dly_ff, data_dly_ff, CNT_MAX, CNT_MAX};
                     state_in = ST_OUT;
                  end else begin
                     pre_in           = pre_ff + 4'd1;
                     div_req.start    = 1'b1;
                     div_req.dividend = DIVIDEND_W'(step_num(pre_ff + 4'd1));
                     div_req.divisor  = DIVISOR_W'(mhz_ff);
                  end
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIVIDEND_W'(low_ns_ff);
                  div_req.divisor  = DIVISOR_W'(div_rsp.quotient[STEP_W-1:0]);
                  state_in         = ST_LOW;
               end
            end
         end
         ST_LOW: begin
            if (div_rsp.done) begin
               qlo_in           = div_rsp.quotient[QUO_W-1:0];
               div_req.start    = 1'b1;
               div_req.dividend = DIVIDEND_W'(high_ns_ff);
               div_req.divisor  = DIVISOR_W'(step_ff);
               state_in         = ST_HIGH;
            end
         end
         ST_HIGH: begin
            if (div_rsp.done) begin
               if (qlo_ff <= FIT_LIMIT && qhi <= FIT_LIMIT) begin
                  // counts minus one, floored at zero
                  word_in = {pre_ff, 4'd0, clk_dly_ff, data_dly_ff,
                             (qhi == '0) ? 8'd0 : 8'(qhi - QUO_W'(1)),
                             (qlo_ff == '0) ? 8'd0 : 8'(qlo_ff - QUO_W'(1))};
                  state_in = ST_OUT;
               end else if (pre_ff == PRE_LAST) begin
                  word_in  = {PRE_LAST, 4'd0, clk_dly_ff, data_dly_ff, CNT_MAX, CNT_MAX};
                  state_in = ST_OUT;
               end else begin
                  pre_in           = pre_ff + 4'd1;
                  div_req.start    = 1'b1;
                  div_req.dividend = DIVIDEND_W'(step_num(pre_ff + 4'd1));
                  div_req.divisor  = DIVISOR_W'(mhz_ff);
                  state_in         = ST_STEP;
               end
            end
         end
         ST_OUT: begin
            if (rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         clk_hz_ff <= CLK_RESET;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            clk_hz_ff <= csr_wdata;
         end
      end
      low_ns_ff   <= low_ns_in;
      high_ns_ff  <= high_ns_in;
      data_dly_ff <= data_dly_in;
      clk_dly_ff  <= clk_dly_in;
      mhz_ff      <= mhz_in;
      pre_ff      <= pre_in;
      step_ff     <= step_in;
      qlo_ff      <= qlo_in;
      word_ff     <= word_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = (state_ff == ST_OUT);
   assign rsp_chan.timing_word = word_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_MHZ)
      else $error("item accepted but clock division not started");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff != ST_IDLE && state_ff != ST_OUT)
      else $error("divider finished outside a wait state");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a response is pending");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> !div_rsp.done)
      else $error("divider done one cycle after start");

endmodule
